// ===== sv/gyro_frame_deframer_crc_check_macros.svh =====
// Assertion macros for the gyro frame deframer.
// Depends on nothing; included by the modules that carry assertions.
`ifndef GYRO_FRAME_DEFRAMER_CRC_CHECK_MACROS_SVH
`define GYRO_FRAME_DEFRAMER_CRC_CHECK_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is asserted.
`define GFD_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |-> (cons)) \
        else $error("gfd assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define GFD_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons) \
    lbl: assert property (@(posedge a_clk) disable iff (!a_rst_n) (ante) |=> (cons)) \
        else $error("gfd assertion failed");
`else
`define GFD_ASSERT_IMP(lbl, a_clk, a_rst_n, ante, cons)
`define GFD_ASSERT_NXT(lbl, a_clk, a_rst_n, ante, cons)
`endif
`endif

// ===== sv/gfd_pkg.sv =====
// Shared types, constants and CRC functions of the gyro frame deframer.
// Depends on nothing; used by every module of the block.
`default_nettype none

package gfd_pkg;

    // Sync sequence and frame layout
    localparam logic [7:0] SYNC0 = 8'hFE;
    localparam logic [7:0] SYNC1 = 8'h81;
    localparam logic [7:0] SYNC2 = 8'hFF;
    localparam logic [7:0] SYNC3 = 8'h55;

    localparam int FRAME_BYTES = 32;
    localparam int CRC_COVERED = 28;
    localparam int RATE_BYTES  = 12;
    localparam int DISC_IDX    = 24;
    localparam int SEQ_IDX     = 25;
    localparam int IDX_W       = $clog2(FRAME_BYTES);
    localparam int LAST_IDX    = FRAME_BYTES - 1;

    // Register defaults (CRC-32/MPEG-2)
    localparam logic [31:0] POLY_RESET   = 32'h04C11DB7;
    localparam logic [31:0] INIT_RESET   = 32'hFFFFFFFF;
    localparam logic [31:0] XOROUT_RESET = 32'h00000000;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_POLY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_XOROUT    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL_IN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REFL_OUT  = 3'd4;

    // Queue depths
    localparam int EVQ_DEPTH  = 8;
    localparam int EVQ_PTR_W  = $clog2(EVQ_DEPTH);
    localparam int RESQ_DEPTH = 2;
    localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);

    typedef enum logic [1:0] {
        STATUS_OK           = 2'd0,
        STATUS_CRC_ERR      = 2'd1,
        STATUS_AXIS_INVALID = 2'd2
    } status_t;

    typedef enum logic {
        EV_START = 1'b0,
        EV_DATA  = 1'b1
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t         kind;
        logic [7:0]       data;
        logic [IDX_W-1:0] idx;
    } event_t;

    typedef struct packed {
        logic [31:0] poly;
        logic [31:0] init;
        logic [31:0] xorout;
        logic        refl_in;
        logic        refl_out;
    } cfg_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] rate_x;
        logic [31:0] rate_y;
        logic [31:0] rate_z;
        logic [7:0]  disc;
        logic [7:0]  seq;
        logic        gap;
    } result_t;

    function automatic logic [7:0] rev8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7-k];
        end
        return r;
    endfunction

    function automatic logic [31:0] rev32(input logic [31:0] v);
        logic [31:0] r;
        for (int k = 0; k < 32; k++) begin
            r[k] = v[31-k];
        end
        return r;
    endfunction

    // One byte through the CRC register, MSB first (LSB first when refl is set)
    function automatic logic [31:0] crc_byte(
        input logic [31:0] crc_in,
        input logic [7:0]  data_in,
        input logic [31:0] poly,
        input logic        refl
    );
        logic [31:0] c;
        logic [7:0]  d;
        logic        top;
        c = crc_in;
        d = refl ? rev8(data_in) : data_in;
        for (int k = 7; k >= 0; k--) begin
            top = c[31] ^ d[k];
            c = {c[30:0], 1'b0};
            if (top) begin
                c = c ^ poly;
            end
        end
        return c;
    endfunction

    function automatic logic [7:0] sync_byte(input logic [1:0] pos);
        logic [7:0] b;
        case (pos)
            2'd0:    b = SYNC0;
            2'd1:    b = SYNC1;
            2'd2:    b = SYNC2;
            default: b = SYNC3;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ===== sv/gfd_front.sv =====
// Front end: sync hunter and payload byte counter.
// Depends on gfd_pkg; feeds the event queue.
`default_nettype none

module gfd_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  wire logic [7:0]      rx_byte,
    output logic                 full,
    output logic                 ev_push,
    output gfd_pkg::event_t      ev,
    input  wire logic            ev_full
);

    typedef enum logic [2:0] {
        S_HUNT,
        S_FE,
        S_81,
        S_FF,
        S_PAYLOAD
    } hunt_state_t;

    hunt_state_t                 hunt_reg;
    logic [gfd_pkg::IDX_W-1:0]   count_reg;
    logic                        accept;

    assign full   = ev_full;
    assign accept = push && !ev_full;

    always_comb
    begin
        ev.kind = (hunt_reg == S_PAYLOAD) ? gfd_pkg::EV_DATA : gfd_pkg::EV_START;
        ev.data = rx_byte;
        ev.idx  = count_reg;
        ev_push = accept && ((hunt_reg == S_PAYLOAD) ||
                             (hunt_reg == S_FF && rx_byte == gfd_pkg::SYNC3));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_reg  <= S_HUNT;
            count_reg <= '0;
        end
        else if (accept)
        begin
            case (hunt_reg)
                S_FE:
                begin
                    hunt_reg <= (rx_byte == gfd_pkg::SYNC1) ? S_81 :
                                (rx_byte == gfd_pkg::SYNC0) ? S_FE : S_HUNT;
                end
                S_81:
                begin
                    hunt_reg <= (rx_byte == gfd_pkg::SYNC2) ? S_FF :
                                (rx_byte == gfd_pkg::SYNC0) ? S_FE : S_HUNT;
                end
                S_FF:
                begin
                    // a stray FE re-arms at the second sync byte
                    hunt_reg  <= (rx_byte == gfd_pkg::SYNC3) ? S_PAYLOAD :
                                 (rx_byte == gfd_pkg::SYNC0) ? S_FE : S_HUNT;
                    count_reg <= '0;
                end
                S_PAYLOAD:
                begin
                    if (count_reg == gfd_pkg::IDX_W'(gfd_pkg::LAST_IDX))
                    begin
                        hunt_reg  <= S_HUNT;
                        count_reg <= '0;
                    end
                    else
                    begin
                        count_reg <= count_reg + 1'b1;
                    end
                end
                default:
                begin
                    hunt_reg <= (rx_byte == gfd_pkg::SYNC0) ? S_FE : S_HUNT;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== sv/gfd_evq.sv =====
// Event queue between the front end and the CRC back end.
// Depends on gfd_pkg.
`default_nettype none

module gfd_evq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  gfd_pkg::event_t       wr_item,
    output logic                  full,
    input  wire logic             pop,
    output gfd_pkg::event_t       rd_item,
    output logic                  empty
);

    gfd_pkg::event_t                 q_reg [gfd_pkg::EVQ_DEPTH];
    logic [gfd_pkg::EVQ_PTR_W-1:0]   wr_ptr_reg;
    logic [gfd_pkg::EVQ_PTR_W-1:0]   rd_ptr_reg;
    logic [gfd_pkg::EVQ_PTR_W:0]     count_reg;
    logic                            do_push;
    logic                            do_pop;

    assign full    = (count_reg == (gfd_pkg::EVQ_PTR_W+1)'(gfd_pkg::EVQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gfd_resq.sv =====
// Result queue that holds finished frame reports for the receiver.
// Depends on gfd_pkg.
`default_nettype none

module gfd_resq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  gfd_pkg::result_t      wr_item,
    output logic                  full,
    input  wire logic             pop,
    output gfd_pkg::result_t      rd_item,
    output logic                  empty
);

    gfd_pkg::result_t                 q_reg [gfd_pkg::RESQ_DEPTH];
    logic [gfd_pkg::RESQ_PTR_W-1:0]   wr_ptr_reg;
    logic [gfd_pkg::RESQ_PTR_W-1:0]   rd_ptr_reg;
    logic [gfd_pkg::RESQ_PTR_W:0]     count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full    = (count_reg == (gfd_pkg::RESQ_PTR_W+1)'(gfd_pkg::RESQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== sv/gfd_back.sv =====
// Back end: CRC engine, field capture, frame check and sequence tracking.
// Depends on gfd_pkg and the assertion macro header.
`default_nettype none
`include "gyro_frame_deframer_crc_check_macros.svh"

module gfd_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  gfd_pkg::cfg_t         cfg,
    input  wire logic             ev_valid,
    input  gfd_pkg::event_t       ev,
    output logic                  ev_pop,
    output logic                  res_push,
    output gfd_pkg::result_t      res,
    input  wire logic             res_full
);

    logic        sync_busy_reg;
    logic [1:0]  sync_step_reg;
    logic [31:0] crc_reg;
    logic [95:0] rate_reg;
    logic [7:0]  disc_reg;
    logic [7:0]  seq_reg;
    logic [23:0] rxcrc_reg;
    logic [7:0]  last_seq_reg;
    logic        have_last_reg;

    logic        head_start;
    logic        head_data;
    logic        head_last;
    logic [31:0] crc_src;
    logic [7:0]  byte_src;
    logic [31:0] crc_step;
    logic [31:0] crc_fin;
    logic [31:0] crc_rx;
    logic        crc_ok;
    logic        axis_ok;
    logic        seq_cont;

    always_comb
    begin
        head_start = ev_valid && ev.kind == gfd_pkg::EV_START;
        head_data  = ev_valid && ev.kind == gfd_pkg::EV_DATA;
        head_last  = head_data && ev.idx == gfd_pkg::IDX_W'(gfd_pkg::LAST_IDX);
        // hold the queue while the sync bytes go through the CRC
        ev_pop     = !sync_busy_reg && (head_start || (head_data && !(head_last && res_full)));
        res_push   = ev_pop && head_last;

        crc_src  = (!sync_busy_reg && head_start) ? cfg.init : crc_reg;
        byte_src = sync_busy_reg ? gfd_pkg::sync_byte(sync_step_reg) :
                   (ev.kind == gfd_pkg::EV_START) ? gfd_pkg::SYNC0 : ev.data;
        crc_step = gfd_pkg::crc_byte(crc_src, byte_src, cfg.poly, cfg.refl_in);

        crc_fin  = (cfg.refl_out ? gfd_pkg::rev32(crc_reg) : crc_reg) ^ cfg.xorout;
        crc_rx   = {rxcrc_reg, ev.data};
        crc_ok   = (crc_fin == crc_rx);
        axis_ok  = &disc_reg[2:0];
        seq_cont = (seq_reg == last_seq_reg + 8'd1) ||
                   ({1'b0, seq_reg} + 9'd127 == {1'b0, last_seq_reg});

        res.rate_x = rate_reg[95:64];
        res.rate_y = rate_reg[63:32];
        res.rate_z = rate_reg[31:0];
        res.disc   = disc_reg;
        res.seq    = seq_reg;
        if (!crc_ok)
        begin
            res.status = gfd_pkg::STATUS_CRC_ERR;
        end
        else if (!axis_ok)
        begin
            res.status = gfd_pkg::STATUS_AXIS_INVALID;
        end
        else
        begin
            res.status = gfd_pkg::STATUS_OK;
        end
        res.gap = crc_ok && axis_ok && have_last_reg && !seq_cont;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_busy_reg <= 1'b0;
            sync_step_reg <= 2'd0;
            last_seq_reg  <= 8'd0;
            have_last_reg <= 1'b0;
        end
        else
        begin
            if (sync_busy_reg)
            begin
                sync_step_reg <= sync_step_reg + 2'd1;
                if (sync_step_reg == 2'd3)
                begin
                    sync_busy_reg <= 1'b0;
                end
            end
            else if (ev_pop && head_start)
            begin
                sync_busy_reg <= 1'b1;
                sync_step_reg <= 2'd1;
            end
            if (res_push && res.status == gfd_pkg::STATUS_OK)
            begin
                last_seq_reg  <= seq_reg;
                have_last_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sync_busy_reg || (ev_pop && head_start))
        begin
            crc_reg <= crc_step;
        end
        else if (ev_pop && head_data && ev.idx < gfd_pkg::IDX_W'(gfd_pkg::CRC_COVERED))
        begin
            crc_reg <= crc_step;
        end

        if (ev_pop && head_data)
        begin
            if (ev.idx < gfd_pkg::IDX_W'(gfd_pkg::RATE_BYTES))
            begin
                rate_reg[{4'(gfd_pkg::RATE_BYTES - 1) - ev.idx[3:0], 3'b000} +: 8] <= ev.data;
            end
            if (ev.idx == gfd_pkg::IDX_W'(gfd_pkg::DISC_IDX))
            begin
                disc_reg <= ev.data;
            end
            if (ev.idx == gfd_pkg::IDX_W'(gfd_pkg::SEQ_IDX))
            begin
                seq_reg <= ev.data;
            end
            if (ev.idx >= gfd_pkg::IDX_W'(gfd_pkg::CRC_COVERED) && !head_last)
            begin
                rxcrc_reg <= {rxcrc_reg[15:0], ev.data};
            end
        end
    end

    `GFD_ASSERT_IMP(a_no_pop_in_sync, clk, rst_n, sync_busy_reg, !ev_pop)
    `GFD_ASSERT_IMP(a_idle_step_zero, clk, rst_n, !sync_busy_reg, sync_step_reg == 2'd0)
    `GFD_ASSERT_NXT(a_start_runs_sync, clk, rst_n, ev_pop && head_start, sync_busy_reg && sync_step_reg == 2'd1)
    `GFD_ASSERT_IMP(a_push_has_room, clk, rst_n, res_push, !res_full && head_last)

endmodule

`default_nettype wire

// ===== sv/gyro_frame_deframer_crc_check.sv =====
// Top level of the gyro frame deframer with CRC check.
// Depends on gfd_pkg, gfd_front, gfd_evq, gfd_back and gfd_resq.
//
// Usage:
//   Received bytes enter on rx_byte; a byte transfers at a clock edge with
//   push high and full low. Each complete frame (FE 81 FF 55 followed by 32
//   payload bytes) yields one report on the result ports, shown while empty
//   is low and transferred at an edge with pop high and empty low.
//   The CRC runs over the sync and payload bytes 0..27 and is compared with
//   the big-endian word in payload bytes 28..31; the status reports ok, CRC
//   mismatch or an axis marked invalid (a clear bit among discrete bits 0..2).
//   Throughput: one byte per cycle, sustained while the receiver takes reports.
//   The back end steps the sync bytes through the CRC at each frame start
//   (one CRC byte step a cycle); at most four events back up behind it,
//   which an eight-entry event queue holds without raising full, and the
//   hunt bytes of the next frame let it drain.
//   Report: written into the result queue when the back end takes the last
//   payload byte, which may wait behind the backlog left by the sync step.
//   Reset: the hunt restarts, both queues empty, no previous sequence number
//   is held, and the CRC registers return to CRC-32/MPEG-2.
//   Stall: while the receiver holds pop low, two reports wait in the result
//   queue; after that the event queue fills and full rises.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once
//   and should only be made while no frame is in flight.
`default_nettype none

module gyro_frame_deframer_crc_check (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             push,
    output logic                                  full,
    input  wire logic [7:0]                       rx_byte,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [1:0]                            frame_status,
    output logic [31:0]                           rate_x_bits,
    output logic [31:0]                           rate_y_bits,
    output logic [31:0]                           rate_z_bits,
    output logic [7:0]                            discrete_flags,
    output logic [7:0]                            sequence_number,
    output logic                                  sequence_gap,
    input  wire logic                             cfg_write,
    input  wire logic [gfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [31:0]                      cfg_data
);

    gfd_pkg::cfg_t      cfg_reg;
    gfd_pkg::event_t    fe_ev;
    gfd_pkg::event_t    evq_head;
    gfd_pkg::result_t   be_res;
    gfd_pkg::result_t   resq_head;
    logic               fe_push;
    logic               evq_full;
    logic               evq_empty;
    logic               be_pop;
    logic               be_push;
    logic               resq_full;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poly     <= gfd_pkg::POLY_RESET;
            cfg_reg.init     <= gfd_pkg::INIT_RESET;
            cfg_reg.xorout   <= gfd_pkg::XOROUT_RESET;
            cfg_reg.refl_in  <= 1'b0;
            cfg_reg.refl_out <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gfd_pkg::CFG_POLY:     cfg_reg.poly     <= cfg_data;
                gfd_pkg::CFG_INIT:     cfg_reg.init     <= cfg_data;
                gfd_pkg::CFG_XOROUT:   cfg_reg.xorout   <= cfg_data;
                gfd_pkg::CFG_REFL_IN:  cfg_reg.refl_in  <= cfg_data[0];
                gfd_pkg::CFG_REFL_OUT: cfg_reg.refl_out <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Front end: hunt for sync, number the payload bytes
    gfd_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .rx_byte (rx_byte),
        .full    (full),
        .ev_push (fe_push),
        .ev      (fe_ev),
        .ev_full (evq_full)
    );

    // Decouple the hunt from the CRC back end
    gfd_evq u_evq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (fe_push),
        .wr_item (fe_ev),
        .full    (evq_full),
        .pop     (be_pop),
        .rd_item (evq_head),
        .empty   (evq_empty)
    );

    // Back end: CRC, field capture and frame verdict
    gfd_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .ev_valid (!evq_empty),
        .ev       (evq_head),
        .ev_pop   (be_pop),
        .res_push (be_push),
        .res      (be_res),
        .res_full (resq_full)
    );

    // Hold finished reports until the receiver takes them
    gfd_resq u_resq (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (be_push),
        .wr_item (be_res),
        .full    (resq_full),
        .pop     (pop),
        .rd_item (resq_head),
        .empty   (empty)
    );

    assign frame_status    = resq_head.status;
    assign rate_x_bits     = resq_head.rate_x;
    assign rate_y_bits     = resq_head.rate_y;
    assign rate_z_bits     = resq_head.rate_z;
    assign discrete_flags  = resq_head.disc;
    assign sequence_number = resq_head.seq;
    assign sequence_gap    = resq_head.gap;

endmodule

`default_nettype wire

// ===== tb/sv/gyro_deframe_checker.sv =====
// Scoreboard for the gyro frame deframer: watches the byte, report and register ports.
// Depends on gfd_pkg for the sync bytes, frame layout, register indexes and status codes.
`timescale 1ns / 100ps

module gyro_deframe_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic [7:0]                    rx_byte,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [1:0]                    frame_status,
    input  logic [31:0]                   rate_x_bits,
    input  logic [31:0]                   rate_y_bits,
    input  logic [31:0]                   rate_z_bits,
    input  logic [7:0]                    discrete_flags,
    input  logic [7:0]                    sequence_number,
    input  logic                          sequence_gap,
    input  logic                          cfg_write,
    input  logic [gfd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data,
    output int                            failures,
    output int                            outstanding
);
    import gfd_pkg::*;

    typedef enum logic [2:0] {
        SEEK_FE,
        SEEK_81,
        SEEK_FF,
        SEEK_55,
        COLLECT
    } hunt_t;

    // Register copies
    logic [31:0] poly = POLY_RESET;
    logic [31:0] init = INIT_RESET;
    logic [31:0] xorout = XOROUT_RESET;
    logic        refl_in = 1'b0;
    logic        refl_out = 1'b0;

    // Deframer state
    hunt_t       hunt = SEEK_FE;
    logic [5:0]  count = '0;
    logic [31:0] crc = '0;
    logic [7:0]  store [FRAME_BYTES];
    logic [7:0]  last_seq = '0;
    logic        have_last = 1'b0;

    result_t     reports [$];
    int          fail_cnt = 0;

    function automatic logic [31:0] crc_advance(input logic [31:0] c, input logic [7:0] b);
        logic [7:0] d;
        logic       fb;
        if (refl_in)
            d = {<<{b}};
        else
            d = b;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[31] ^ d[k];
            c = c << 1;
            if (fb)
                c = c ^ poly;
        end
        return c;
    endfunction

    // A stray first sync byte re-arms the hunt at the second one
    function automatic hunt_t rearm(input logic [7:0] b);
        return (b == SYNC0) ? SEEK_81 : SEEK_FE;
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        result_t     rep;
        logic [31:0] fin;
        logic [31:0] rx_crc;
        int          d;
        case (hunt)
            SEEK_81: hunt = (b == SYNC1) ? SEEK_FF : rearm(b);
            SEEK_FF: hunt = (b == SYNC2) ? SEEK_55 : rearm(b);
            SEEK_55:
            begin
                if (b == SYNC3)
                begin
                    hunt = COLLECT;
                    count = '0;
                    crc = crc_advance(init, SYNC0);
                    crc = crc_advance(crc, SYNC1);
                    crc = crc_advance(crc, SYNC2);
                    crc = crc_advance(crc, SYNC3);
                end
                else
                    hunt = rearm(b);
            end
            COLLECT:
            begin
                store[count[4:0]] = b;
                if (count < CRC_COVERED)
                    crc = crc_advance(crc, b);
                count = count + 6'd1;
                if (count == FRAME_BYTES)
                begin
                    count = '0;
                    hunt = SEEK_FE;
                    fin = crc;
                    if (refl_out)
                        fin = {<<{crc}};
                    fin = fin ^ xorout;
                    rx_crc = {store[28], store[29], store[30], store[31]};
                    rep.rate_x = {store[0], store[1], store[2], store[3]};
                    rep.rate_y = {store[4], store[5], store[6], store[7]};
                    rep.rate_z = {store[8], store[9], store[10], store[11]};
                    rep.disc = store[DISC_IDX];
                    rep.seq = store[SEQ_IDX];
                    rep.gap = 1'b0;
                    if (fin != rx_crc)
                        rep.status = STATUS_CRC_ERR;
                    else if (rep.disc[2:0] != 3'b111)
                        rep.status = STATUS_AXIS_INVALID;
                    else
                    begin
                        rep.status = STATUS_OK;
                        d = int'(rep.seq) - int'(last_seq);
                        if (have_last && ((d + 256) % 256) != 1 && d != -127)
                            rep.gap = 1'b1;
                        last_seq = rep.seq;
                        have_last = 1'b1;
                    end
                    reports.push_back(rep);
                end
            end
            default: hunt = rearm(b);
        endcase
    endfunction

    function automatic bit field_bad(input string name, input logic [31:0] want,
                                     input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        bit      bad;
        if (!rst_n)
        begin
            poly = POLY_RESET;
            init = INIT_RESET;
            xorout = XOROUT_RESET;
            refl_in = 1'b0;
            refl_out = 1'b0;
            hunt = SEEK_FE;
            count = '0;
            crc = '0;
            last_seq = '0;
            have_last = 1'b0;
            reports.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_POLY:     poly = cfg_data;
                    CFG_INIT:     init = cfg_data;
                    CFG_XOROUT:   xorout = cfg_data;
                    CFG_REFL_IN:  refl_in = cfg_data[0];
                    CFG_REFL_OUT: refl_out = cfg_data[0];
                    default: ;
                endcase
            end
            if (pop && !empty)
            begin
                if (reports.size() == 0)
                begin
                    $display("%0t: report expected none, got status %0d seq 0x%0h",
                             $time, frame_status, sequence_number);
                    fail_cnt++;
                end
                else
                begin
                    want = reports.pop_front();
                    bad = 1'b0;
                    bad |= field_bad("frame_status", 32'(want.status), 32'(frame_status));
                    bad |= field_bad("rate_x_bits", want.rate_x, rate_x_bits);
                    bad |= field_bad("rate_y_bits", want.rate_y, rate_y_bits);
                    bad |= field_bad("rate_z_bits", want.rate_z, rate_z_bits);
                    bad |= field_bad("discrete_flags", 32'(want.disc), 32'(discrete_flags));
                    bad |= field_bad("sequence_number", 32'(want.seq), 32'(sequence_number));
                    bad |= field_bad("sequence_gap", 32'(want.gap), 32'(sequence_gap));
                    if (bad)
                        fail_cnt++;
                end
            end
            if (push && !full)
                deframe_byte(rx_byte);
        end
        failures <= fail_cnt;
        outstanding <= reports.size();
    end

endmodule

// ===== tb/sv/tb_gyro_frame_deframer_crc_check.sv =====
// Testbench top for the gyro frame deframer: clock, reset, byte and register stimulus, verdict.
// Depends on gfd_pkg, the block itself and gyro_deframe_checker.
`timescale 1ns / 100ps

module tb_gyro_frame_deframer_crc_check;
    import gfd_pkg::*;

    localparam logic [31:0] SYNC_WORD = {SYNC0, SYNC1, SYNC2, SYNC3};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 push;
    logic                 full;
    logic [7:0]           rx_byte;
    logic                 empty;
    logic                 pop;
    logic [1:0]           frame_status;
    logic [31:0]          rate_x_bits;
    logic [31:0]          rate_y_bits;
    logic [31:0]          rate_z_bits;
    logic [7:0]           discrete_flags;
    logic [7:0]           sequence_number;
    logic                 sequence_gap;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    int                   failures;
    int                   outstanding;

    // CRC settings currently loaded, used to build frames with a matching check word
    logic [31:0] tx_poly = POLY_RESET;
    logic [31:0] tx_init = INIT_RESET;
    logic [31:0] tx_xorout = XOROUT_RESET;
    logic        tx_rin = 1'b0;
    logic        tx_rout = 1'b0;

    int          tx_count = 0;      // bytes transferred so far
    bit          tx_idle_on = 1'b1;  // sender inserts random gaps
    bit          rx_stall_on = 1'b1; // receiver inserts random stalls
    int          rx_hold_len = 0;    // request for one long receiver hold-off
    logic [7:0]  prev_seq = '0;      // sequence number of the last frame sent as good

    always #5 clk = ~clk;

    gyro_frame_deframer_crc_check dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .empty           (empty),
        .pop             (pop),
        .frame_status    (frame_status),
        .rate_x_bits     (rate_x_bits),
        .rate_y_bits     (rate_y_bits),
        .rate_z_bits     (rate_z_bits),
        .discrete_flags  (discrete_flags),
        .sequence_number (sequence_number),
        .sequence_gap    (sequence_gap),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    gyro_deframe_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .rx_byte         (rx_byte),
        .empty           (empty),
        .pop             (pop),
        .frame_status    (frame_status),
        .rate_x_bits     (rate_x_bits),
        .rate_y_bits     (rate_y_bits),
        .rate_z_bits     (rate_z_bits),
        .discrete_flags  (discrete_flags),
        .sequence_number (sequence_number),
        .sequence_gap    (sequence_gap),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .failures        (failures),
        .outstanding     (outstanding)
    );

    // Gap length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    // One byte through the CRC register under the loaded settings
    function automatic logic [31:0] crc_feed(input logic [31:0] c, input logic [7:0] b);
        logic [7:0] d;
        logic       fb;
        if (tx_rin)
            d = {<<{b}};
        else
            d = b;
        for (int k = 7; k >= 0; k--)
        begin
            fb = c[31] ^ d[k];
            c = c << 1;
            if (fb)
                c = c ^ tx_poly;
        end
        return c;
    endfunction

    // Offer one byte and hold it until the transfer; push stays high for a
    // back-to-back byte and drops only when a gap is due.
    task automatic send_byte(input logic [7:0] b);
        int n;
        n = tx_idle_on ? idle_len() : 0;
        if (n > 0)
        begin
            push <= 1'b0;
            repeat (n) @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        tx_count++;
    endtask

    task automatic send_sync();
        for (int k = 0; k < 4; k++)
            send_byte(SYNC_WORD[31-8*k -: 8]);
    endtask

    // Build a complete frame: fill < 0 gives random payload, otherwise every
    // byte takes the fill value before the flags and sequence go in. The check
    // word covers the sync and bytes 0..27; corrupt flips one random bit after.
    task automatic send_frame(input logic [7:0] seq, input logic [7:0] disc,
                              input int fill, input bit corrupt);
        logic [7:0]  body [FRAME_BYTES];
        logic [31:0] c;
        int          pos;
        for (int k = 0; k < FRAME_BYTES; k++)
            body[k] = (fill < 0) ? 8'($urandom) : 8'(fill);
        body[DISC_IDX] = disc;
        body[SEQ_IDX] = seq;
        c = tx_init;
        for (int k = 0; k < 4; k++)
            c = crc_feed(c, SYNC_WORD[31-8*k -: 8]);
        for (int k = 0; k < CRC_COVERED; k++)
            c = crc_feed(c, body[k]);
        if (tx_rout)
            c = {<<{c}};
        c = c ^ tx_xorout;
        {body[28], body[29], body[30], body[31]} = c;
        if (corrupt)
        begin
            pos = $urandom_range(0, FRAME_BYTES - 1);
            body[pos] = body[pos] ^ (8'd1 << $urandom_range(0, 7));
        end
        send_sync();
        for (int k = 0; k < FRAME_BYTES; k++)
            send_byte(body[k]);
    endtask

    // Complete frame, random content, at times bad CRC or an invalid axis; the sequence
    // mostly advances by one, sometimes jumps back by 127 and sometimes lands anywhere.
    task automatic random_frame();
        logic [7:0] s;
        logic [7:0] dsc;
        bit         bad_crc;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 65)
            s = prev_seq + 8'd1;
        else if (r < 80)
            s = prev_seq - 8'd127;
        else
            s = 8'($urandom);
        dsc = ($urandom_range(0, 99) < 80) ? (8'($urandom) | 8'h07) : 8'($urandom);
        bad_crc = ($urandom_range(0, 99) < 10);
        send_frame(s, dsc, -1, bad_crc);
        if (!bad_crc && dsc[2:0] == 3'b111)
            prev_seq = s;
    endtask

    // Mostly good frames; the rest is broken sync, noise rich in stray first
    // sync bytes, and frames cut short so the next bytes are swallowed.
    task automatic random_traffic(input int budget);
        int goal;
        int r;
        int n;
        goal = tx_count + budget;
        while (tx_count < goal)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                random_frame();
            else if (r < 80)
            begin
                n = $urandom_range(1, 3);
                for (int k = 0; k < n; k++)
                    send_byte(SYNC_WORD[31-8*k -: 8]);
                send_byte(8'($urandom));
            end
            else if (r < 90)
            begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    send_byte(($urandom_range(0, 3) == 0) ? SYNC0 : 8'($urandom));
            end
            else
            begin
                send_sync();
                n = $urandom_range(1, FRAME_BYTES - 1);
                for (int k = 0; k < n; k++)
                    send_byte(8'($urandom));
            end
            // Toggle sender gaps and receiver stalls now and then for stretches without them
            if ($urandom_range(0, 9) == 0)
                tx_idle_on = !tx_idle_on;
            if ($urandom_range(0, 9) == 0)
                rx_stall_on = !rx_stall_on;
        end
    endtask

    // Flush with zero bytes so any frame in flight completes and the hunt is
    // back at its start, stop sending, wait for every report, then let the
    // block run dry.
    task automatic settle();
        for (int k = 0; k < FRAME_BYTES + 1; k++)
            send_byte(8'h00);
        push <= 1'b0;
        repeat (2) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_crc(input logic [31:0] p, input logic [31:0] i, input logic [31:0] x,
                           input logic ri, input logic ro);
        put_reg(CFG_POLY, p);
        put_reg(CFG_INIT, i);
        put_reg(CFG_XOROUT, x);
        put_reg(CFG_REFL_IN, 32'(ri));
        put_reg(CFG_REFL_OUT, 32'(ro));
        cfg_write <= 1'b0;
        tx_poly = p;
        tx_init = i;
        tx_xorout = x;
        tx_rin = ri;
        tx_rout = ro;
    endtask

    // Receiver: pop with random stalls, or hold off for a requested stretch
    // counted here while the sender keeps offering bytes.
    initial
    begin
        int n;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (rx_hold_len > 0)
            begin
                n = rx_hold_len;
                rx_hold_len = 0;
                pop <= 1'b0;
                repeat (n) @(posedge clk);
            end
            else
            begin
                n = rx_stall_on ? idle_len() : 0;
                if (n > 0)
                begin
                    pop <= 1'b0;
                    repeat (n) @(posedge clk);
                end
                pop <= 1'b1;
                @(posedge clk);
            end
        end
    end

    // Guard against a hung run
    initial
    begin
        #5_000_000;
        $display("[gyro_frame_deframer_crc_check] ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push <= 1'b0;
        rx_byte <= 8'h00;
        cfg_write <= 1'b0;
        cfg_index <= CFG_POLY;
        cfg_data <= 32'h0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset settings (CRC-32/MPEG-2).
        // Sync broken at its last byte, then a stray first sync byte that
        // re-arms the hunt just ahead of a real frame.
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(SYNC2);
        send_byte(8'h00);
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(SYNC0);
        // First good frame, all-zero rates: no gap since nothing came before
        send_frame(8'h00, 8'h07, 8'h00, 1'b0);
        // All-one payload: sequence jumps, so a gap
        send_frame(8'hFF, 8'hFF, 8'hFF, 1'b0);
        // Stray first sync byte in place of the fourth
        send_byte(SYNC0);
        send_byte(SYNC1);
        send_byte(SYNC2);
        send_byte(SYNC0);
        // Sequence wraps from FF to 00: no gap
        send_frame(8'h00, 8'hFF, -1, 1'b0);
        send_frame(8'd200, 8'h07, -1, 1'b0);
        // Back by exactly 127: counts as continuous
        send_frame(8'd73, 8'h07, -1, 1'b0);
        // Each axis marked invalid in turn, and a frame with one flipped bit
        send_frame(8'd74, 8'h06, -1, 1'b0);
        send_frame(8'd74, 8'h05, -1, 1'b0);
        send_frame(8'd74, 8'hFB, -1, 1'b0);
        send_frame(8'd74, 8'h07, -1, 1'b1);
        send_frame(8'd74, 8'h07, -1, 1'b0);
        prev_seq = 8'd74;
        settle();

        // Random phases, each under its own CRC settings
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_crc(32'h04C11DB7, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b1);
                1: set_crc(32'h00000000, 32'h00000000, 32'h00000000, 1'b0, 1'b0);
                2: set_crc(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1, 1'b0);
                3: set_crc($urandom, $urandom, $urandom, 1'($urandom), 1'($urandom));
                default: set_crc(POLY_RESET, INIT_RESET, XOROUT_RESET, 1'b0, 1'b1);
            endcase
            random_traffic(150);
            if (ph == 4)
            begin
                // Hold the receiver off while frames stream in back to back,
                // so the report queue fills and full stalls the sender.
                tx_idle_on = 1'b0;
                rx_hold_len = 400;
                for (int k = 0; k < 6; k++)
                    random_frame();
                tx_idle_on = 1'b1;
            end
            settle();
        end

        if (failures == 0)
            $display("[gyro_frame_deframer_crc_check] OK");
        else
            $display("[gyro_frame_deframer_crc_check] ERROR");
        $finish;
    end

endmodule
